// ----- sv/lls_pkg.sv -----
// ============================================================================
// Lane line steering decision package
// Shared widths, codes, the configuration and item types, and small helpers.
// ============================================================================
package lls_pkg;

    localparam int LIM_W     = 15;
    localparam int SLOPE_W   = 16;
    localparam int PTS_W     = 12;
    localparam int DEN_W     = PTS_W + 1;
    localparam int STEER_W   = 16;
    localparam int PATH_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int OPA_W     = SLOPE_W + 1;
    localparam int OPB_W     = DEN_W;
    localparam int ACC_W     = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_V   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_V    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_V     = 3'd6;

    localparam logic [PATH_W-1:0] PATH_HELD  = 2'd0;
    localparam logic [PATH_W-1:0] PATH_CLEAR = 2'd1;
    localparam logic [PATH_W-1:0] PATH_NEAR  = 2'd2;
    localparam logic [PATH_W-1:0] PATH_ONE   = 2'd3;

    typedef struct packed {
        logic [LIM_W-1:0] center;
        logic [LIM_W-1:0] straight;
        logic [LIM_W-1:0] small_lim;
        logic [LIM_W-1:0] turn_lim;
        logic [LIM_W-1:0] small_v;
        logic [LIM_W-1:0] turn_v;
        logic [LIM_W-1:0] max_v;
    } t_cfg;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope_a;
        logic signed [SLOPE_W-1:0] offset_a;
        logic [PTS_W-1:0]          points_a;
        logic                      found_a;
        logic signed [SLOPE_W-1:0] slope_b;
        logic signed [SLOPE_W-1:0] offset_b;
        logic [PTS_W-1:0]          points_b;
        logic                      found_b;
    } t_item;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        logic    prod_en;
        t_acc_op acc_op;
    } t_mac_ctl;

    // Fixed-point reset value of tenths/10, rounded and saturated to 15 bits.
    function automatic logic [LIM_W-1:0] q_tenths(int unsigned tenths, int unsigned frac);
        longint unsigned v;
        v = ((longint'(tenths) << frac) + 5) / 10;
        if (v > 32767) begin
            return 15'h7fff;
        end
        return LIM_W'(v);
    endfunction

    // Magnitude of a 16-bit signed value; the most negative value gives 32768.
    function automatic logic [SLOPE_W:0] abs16(logic signed [SLOPE_W-1:0] v);
        logic signed [SLOPE_W:0] w;
        w = {v[SLOPE_W-1], v};
        if (w[SLOPE_W]) begin
            return (SLOPE_W+1)'(-w);
        end
        return (SLOPE_W+1)'(w);
    endfunction

endpackage

// ----- sv/lls_mac.sv -----
// ============================================================================
// Shared multiply-accumulate unit
// One signed multiplier with a registered product and an accumulator behind it.
// ============================================================================
module lls_mac (
    input  logic                              i_clk,
    input  lls_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [lls_pkg::OPA_W-1:0]  i_op_a,
    input  logic [lls_pkg::OPB_W-1:0]         i_op_b,
    output logic signed [lls_pkg::ACC_W-1:0]  o_prod,
    output logic signed [lls_pkg::ACC_W-1:0]  o_acc
);
    import lls_pkg::*;

    logic signed [OPA_W+OPB_W:0] w_full;
    logic signed [ACC_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]     r_acc;

    // All products used here stay below 2^28 in magnitude.
    assign w_full = i_op_a * $signed({1'b0, i_op_b});

    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            r_prod <= w_full[ACC_W-1:0];
        end
        case (i_ctl.acc_op)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            default:  r_acc <= r_acc;
        endcase
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

// ----- sv/lls_seq.sv -----
// ============================================================================
// Steering decision sequencer
// Steps the shared multiplier through the mean numerator and the scaled
// thresholds, then picks the steering value and holds it in the output stage.
// ============================================================================
module lls_seq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lls_pkg::t_cfg                      i_cfg,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  lls_pkg::t_item                     i_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [lls_pkg::STEER_W-1:0] o_steer,
    output logic [lls_pkg::PATH_W-1:0]         o_path
);
    import lls_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MA   = 8'b0000_0010,
        S_MB   = 8'b0000_0100,
        S_NUM  = 8'b0000_1000,
        S_T1   = 8'b0001_0000,
        S_T2   = 8'b0010_0000,
        S_T3   = 8'b0100_0000,
        S_DEC  = 8'b1000_0000
    } t_state;

    t_state                    r_state, n_state;
    t_item                     r_item;
    logic signed [STEER_W-1:0] r_held;
    logic                      r_ovalid;
    logic signed [STEER_W-1:0] r_osteer;
    logic [PATH_W-1:0]         r_opath;
    logic                      r_gt_st, r_ge_sm, r_ge_tu;

    t_mac_ctl                  w_ctl;
    logic signed [OPA_W-1:0]   w_op_a;
    logic [OPB_W-1:0]          w_op_b;
    logic signed [ACC_W-1:0]   w_prod, w_acc;
    logic [ACC_W-1:0]          w_an;
    logic [DEN_W-1:0]          w_den_sum, w_den;
    logic                      w_da, w_db;
    logic signed [SLOPE_W-1:0] w_lo, w_ro;
    logic                      w_near_l, w_near_r;
    logic                      w_num_neg, w_num_pos;
    logic [LIM_W-1:0]          w_mag;
    logic                      w_out_free, w_out_load;
    logic signed [STEER_W-1:0] n_steer;
    logic [PATH_W-1:0]         n_path;

    function automatic logic signed [STEER_W-1:0] one_line(
        logic signed [SLOPE_W-1:0] s,
        logic signed [SLOPE_W-1:0] o,
        t_cfg                      c
    );
        logic [SLOPE_W:0]          as_v;
        logic [SLOPE_W:0]          ao_v;
        logic signed [STEER_W-1:0] r;
        as_v = abs16(s);
        ao_v = abs16(o);
        if (ao_v < {2'b00, c.center}) begin
            if (as_v < {2'b00, c.straight}) begin
                r = '0;
            end else if (s > 0) begin
                r = $signed({1'b0, c.turn_v});
            end else begin
                r = -$signed({1'b0, c.turn_v});
            end
        end else if (as_v < {2'b00, c.straight}) begin
            r = '0;
        end else if (as_v < {2'b00, c.small_lim}) begin
            r = $signed({1'b0, c.small_v});
        end else if (as_v < {2'b00, c.turn_lim}) begin
            r = $signed({1'b0, c.turn_v});
        end else begin
            r = $signed({1'b0, c.max_v});
        end
        return r;
    endfunction

    lls_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_prod (w_prod),
        .o_acc  (w_acc)
    );

    // A zero total count divides by one, so every threshold equals its limit.
    assign w_den_sum = {1'b0, r_item.points_a} + {1'b0, r_item.points_b};
    assign w_den     = (w_den_sum == '0) ? DEN_W'(1) : w_den_sum;
    assign w_an      = w_acc[ACC_W-1] ? ACC_W'(-w_acc) : ACC_W'(w_acc);

    always_comb begin
        w_ctl.prod_en = (r_state != S_IDLE);
        w_ctl.acc_op  = ACC_HOLD;
        w_op_a        = '0;
        w_op_b        = '0;
        case (r_state)
            S_MA: begin
                w_op_a = OPA_W'(r_item.slope_a);
                w_op_b = {1'b0, r_item.points_a};
            end
            S_MB: begin
                w_op_a       = OPA_W'(r_item.slope_b);
                w_op_b       = {1'b0, r_item.points_b};
                w_ctl.acc_op = ACC_LOAD;
            end
            S_NUM: begin
                w_op_a       = $signed({2'b00, i_cfg.straight});
                w_op_b       = w_den;
                w_ctl.acc_op = ACC_ADD;
            end
            S_T1: begin
                w_op_a = $signed({2'b00, i_cfg.small_lim});
                w_op_b = w_den;
            end
            S_T2: begin
                w_op_a = $signed({2'b00, i_cfg.turn_lim});
                w_op_b = w_den;
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_da      = r_item.found_a && (r_item.offset_a != '0);
    assign w_db      = r_item.found_b && (r_item.offset_b != '0);
    // On equal offsets the second line is the left one.
    assign w_lo      = (r_item.offset_a > r_item.offset_b) ? r_item.offset_a : r_item.offset_b;
    assign w_ro      = (r_item.offset_a > r_item.offset_b) ? r_item.offset_b : r_item.offset_a;
    assign w_near_l  = abs16(w_lo) < {2'b00, i_cfg.center};
    assign w_near_r  = abs16(w_ro) < {2'b00, i_cfg.center};
    assign w_num_neg = w_acc < 0;
    assign w_num_pos = w_acc > 0;

    always_comb begin
        if (r_gt_st && !r_ge_sm) begin
            w_mag = i_cfg.small_v;
        end else if (r_ge_sm && !r_ge_tu) begin
            w_mag = i_cfg.turn_v;
        end else if (r_ge_tu) begin
            w_mag = i_cfg.max_v;
        end else begin
            w_mag = '0;
        end
    end

    always_comb begin
        n_steer = r_held;
        n_path  = PATH_HELD;
        if (w_da && w_db) begin
            if (w_near_l || w_near_r) begin
                n_path = PATH_NEAR;
                // A zero mean keeps the held value.
                if (w_near_l) begin
                    if (w_num_neg) begin
                        n_steer = -$signed({1'b0, i_cfg.max_v});
                    end else if (w_num_pos) begin
                        n_steer = $signed({1'b0, i_cfg.small_v});
                    end
                end else begin
                    if (w_num_neg) begin
                        n_steer = $signed({1'b0, i_cfg.small_v});
                    end else if (w_num_pos) begin
                        n_steer = $signed({1'b0, i_cfg.max_v});
                    end
                end
            end else begin
                n_path  = PATH_CLEAR;
                n_steer = w_num_pos ? $signed({1'b0, w_mag}) : -$signed({1'b0, w_mag});
            end
        end else if (w_da) begin
            n_path  = PATH_ONE;
            n_steer = one_line(r_item.slope_a, r_item.offset_a, i_cfg);
        end else if (w_db) begin
            n_path  = PATH_ONE;
            n_steer = one_line(r_item.slope_b, r_item.offset_b, i_cfg);
        end
    end

    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_out_load = (r_state == S_DEC) && w_out_free;

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = i_in_valid ? S_MA : S_IDLE;
            S_MA:    n_state = S_MB;
            S_MB:    n_state = S_NUM;
            S_NUM:   n_state = S_T1;
            S_T1:    n_state = S_T2;
            S_T2:    n_state = S_T3;
            S_T3:    n_state = S_DEC;
            S_DEC:   n_state = w_out_free ? S_IDLE : S_DEC;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_held   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_held   <= n_steer;
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_item;
        end
        case (r_state)
            S_T1:    r_gt_st <= w_an > ACC_W'(w_prod);
            S_T2:    r_ge_sm <= w_an >= ACC_W'(w_prod);
            S_T3:    r_ge_tu <= w_an >= ACC_W'(w_prod);
            default: r_gt_st <= r_gt_st;
        endcase
        if (w_out_load) begin
            r_osteer <= n_steer;
            r_opath  <= n_path;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_steer     = r_osteer;
    assign o_path      = r_opath;

    a_held_only_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_out_load |=> $stable(r_held))
        else $error("held steering changed without a result");

    a_no_line_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && n_path == PATH_HELD) |-> (n_steer == r_held))
        else $error("no-line result differs from the held value");

    a_clear_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && n_path == PATH_CLEAR && n_steer < 0) |-> !w_num_pos)
        else $error("clear-road turn sign disagrees with the mean slope");

endmodule

// ----- sv/lane_line_steering_decision_unit.sv -----
// ============================================================================
// Lane line steering decision unit
// Chooses a steering command from two fitted lane lines per item.
// ============================================================================
//  Channel   Direction  Ports                       Payload
//  s_axis    in         tvalid/tready/tdata/tuser   two fitted lines
//  m_axis    out        tvalid/tready/tdata/tuser   steering and decision path
//  cfg       in         i_cfg_we/idx/data           seven 15-bit limits
//
//  An item runs five multiplier passes, the last compare and the decision
//  to reach the result register; the next is taken once it leaves that step.
//  The input is not ready while an item is in work; it is ready again while
//  a result waits, and an item stalls in its decision step until the result
//  register is free. Reset (synchronous, active low) restores the default
//  limits and clears the held steering value.
module lane_line_steering_decision_unit #(
    parameter int FRAC_BITS        = 12,
    parameter int MAX_CLOUD_POINTS = 4095
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // slope_a[15:0], offset_a[31:16], points_a[43:32],
    // slope_b[59:44], offset_b[75:60], points_b[87:76]
    input  logic [87:0]                       s_axis_tdata,
    // found_a[0], found_b[1]
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // steer_value[15:0]
    output logic [15:0]                       m_axis_tdata,
    // decision_path[1:0]
    output logic [1:0]                        m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [lls_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lls_pkg::LIM_W-1:0]         i_cfg_data
);
    import lls_pkg::*;

    localparam logic [LIM_W-1:0] RST_CENTER    = q_tenths(3, FRAC_BITS);
    localparam logic [LIM_W-1:0] RST_STRAIGHT  = q_tenths(2, FRAC_BITS);
    localparam logic [LIM_W-1:0] RST_SMALL_LIM = q_tenths(4, FRAC_BITS);
    localparam logic [LIM_W-1:0] RST_TURN_LIM  = q_tenths(10, FRAC_BITS);
    localparam logic [LIM_W-1:0] RST_SMALL_V   = q_tenths(2, FRAC_BITS);
    localparam logic [LIM_W-1:0] RST_TURN_V    = q_tenths(3, FRAC_BITS);
    localparam logic [LIM_W-1:0] RST_MAX_V     = q_tenths(4, FRAC_BITS);
    localparam logic [15:0]      MAX_PTS       = 16'(MAX_CLOUD_POINTS);

    t_cfg                      r_cfg;
    t_item                     w_item;
    logic [PTS_W-1:0]          w_pa_raw, w_pb_raw;
    logic signed [STEER_W-1:0] w_steer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center    <= RST_CENTER;
            r_cfg.straight  <= RST_STRAIGHT;
            r_cfg.small_lim <= RST_SMALL_LIM;
            r_cfg.turn_lim  <= RST_TURN_LIM;
            r_cfg.small_v   <= RST_SMALL_V;
            r_cfg.turn_v    <= RST_TURN_V;
            r_cfg.max_v     <= RST_MAX_V;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER:    r_cfg.center    <= i_cfg_data;
                CFG_STRAIGHT:  r_cfg.straight  <= i_cfg_data;
                CFG_SMALL_LIM: r_cfg.small_lim <= i_cfg_data;
                CFG_TURN_LIM:  r_cfg.turn_lim  <= i_cfg_data;
                CFG_SMALL_V:   r_cfg.small_v   <= i_cfg_data;
                CFG_TURN_V:    r_cfg.turn_v    <= i_cfg_data;
                CFG_MAX_V:     r_cfg.max_v     <= i_cfg_data;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    assign w_pa_raw = s_axis_tdata[43:32];
    assign w_pb_raw = s_axis_tdata[87:76];

    // Point counts saturate at the cloud size limit.
    always_comb begin
        w_item.slope_a  = $signed(s_axis_tdata[15:0]);
        w_item.offset_a = $signed(s_axis_tdata[31:16]);
        w_item.points_a = ({4'b0, w_pa_raw} > MAX_PTS) ? MAX_PTS[PTS_W-1:0] : w_pa_raw;
        w_item.found_a  = s_axis_tuser[0];
        w_item.slope_b  = $signed(s_axis_tdata[59:44]);
        w_item.offset_b = $signed(s_axis_tdata[75:60]);
        w_item.points_b = ({4'b0, w_pb_raw} > MAX_PTS) ? MAX_PTS[PTS_W-1:0] : w_pb_raw;
        w_item.found_b  = s_axis_tuser[1];
    end

    lls_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_item      (w_item),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_steer     (w_steer),
        .o_path      (m_axis_tuser)
    );

    assign m_axis_tdata = w_steer;

endmodule
